// File: design/gclp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gclp_pkg
// Shared types and constants of the G-code line parser: character codes,
// field mask bit positions, register indexes and controller/datapath links.
// ----------------------------------------------------------------------------
package gclp_pkg;

    // Register indexes of the configuration port
    localparam logic [2:0] REG_SCALE_X   = 3'd0;
    localparam logic [2:0] REG_SCALE_Y   = 3'd1;
    localparam logic [2:0] REG_SCALE_Z   = 3'd2;
    localparam logic [2:0] REG_SCALE_EXT = 3'd3;
    localparam logic [2:0] REG_INCH      = 3'd4;
    localparam logic [2:0] REG_RELATIVE  = 3'd5;
    localparam logic [2:0] REG_CHECK     = 3'd6;
    localparam logic [2:0] REG_PID       = 3'd7;

    localparam int CfgIdxWidth  = 3;
    localparam int CfgDataWidth = 24;
    localparam int OutWidth     = 256;

    // Field mask bit positions
    localparam int BIT_G  = 0;
    localparam int BIT_M  = 1;
    localparam int BIT_X  = 2;
    localparam int BIT_Y  = 3;
    localparam int BIT_Z  = 4;
    localparam int BIT_E  = 5;
    localparam int BIT_F  = 6;
    localparam int BIT_S  = 7;
    localparam int BIT_P  = 8;
    localparam int BIT_N  = 9;
    localparam int BIT_CS = 10;

    // Character codes
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_Z     = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_X     = 8'h58;
    localparam logic [7:0] CH_Y     = 8'h59;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_N     = 8'h4E;

    // Result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_LINE_N = 2'd1;
    localparam logic [1:0] ST_CSUM   = 2'd2;

    // M codes with special S scaling, and the G code with special P scaling
    localparam logic [7:0] M_TEMP_A = 8'd104;
    localparam logic [7:0] M_TEMP_B = 8'd109;
    localparam logic [7:0] M_PID_LO = 8'd130;
    localparam logic [7:0] M_PID_HI = 8'd132;
    localparam logic [7:0] G_DWELL  = 8'd4;

    // Reciprocal of ten for 32-bit truncating division
    localparam logic [31:0] RECIP_10 = 32'hCCCCCCCD;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic mul;
        logic div;
        logic commit;
        logic chr;
        logic eol;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic need_close;
        logic div_done;
        logic is_eol;
    } sts_t;

endpackage

// File: design/gclp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gclp_ctrl
// Sequencer for one character: decode, optional field close (multiply,
// divide and commit steps), character update and line-end result.
// ----------------------------------------------------------------------------
module gclp_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  logic           m_tready,
    input  gclp_pkg::sts_t sts,
    output gclp_pkg::cmd_t cmd
);
    import gclp_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_MUL    = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;
    localparam logic [2:0] S_COMMIT = 3'd4;
    localparam logic [2:0] S_CHAR   = 3'd5;
    localparam logic [2:0] S_EOL    = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       valid_reg, valid_next;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: state_next = sts.need_close ? S_MUL : S_CHAR;
            S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = S_DIV;
            end
            S_DIV: begin
                if (sts.div_done) begin
                    state_next = S_COMMIT;
                end else begin
                    cmd.div = 1'b1;
                end
            end
            S_COMMIT: begin
                cmd.commit = 1'b1;
                state_next = S_CHAR;
            end
            S_CHAR: begin
                cmd.chr    = 1'b1;
                state_next = sts.is_eol ? S_EOL : S_IDLE;
            end
            S_EOL: begin
                if (!valid_reg || m_tready) begin
                    cmd.eol    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Hold the result until the transfer completes
    always_comb begin
        valid_next = valid_reg;
        if (cmd.eol) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    assign m_tvalid = valid_reg;

endmodule

// File: design/gclp_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gclp_dp
// Parser datapath: configuration registers, number accumulator, field
// scaling unit (one multiply, then one divide-by-ten per cycle), line state
// and the result register.
// ----------------------------------------------------------------------------
module gclp_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [7:0]                          s_tdata,
    input  logic                                cfg_wr_en,
    input  logic [gclp_pkg::CfgIdxWidth-1:0]    cfg_index,
    input  logic [gclp_pkg::CfgDataWidth-1:0]   cfg_wdata,
    input  gclp_pkg::cmd_t                      cmd,
    output gclp_pkg::sts_t                      sts,
    output logic [gclp_pkg::OutWidth-1:0]       m_tdata
);
    import gclp_pkg::*;

    // Configuration
    logic [23:0] scale_x_reg, scale_y_reg, scale_z_reg, scale_e_reg;
    logic        inch_reg, rel_reg;
    logic [1:0]  check_reg;
    logic [15:0] pid_reg;

    // Per-character and per-line state
    logic [7:0]  char_reg;
    logic [7:0]  pend_reg;
    logic        sign_reg;
    logic [31:0] mant_reg;
    logic [7:0]  exp_reg;
    logic [7:0]  g_reg, m_reg;
    logic [10:0] seen_reg;
    logic        semi_reg, paren_reg;
    logic [31:0] tx_reg, ty_reg, tz_reg, te_reg, tf_reg;
    logic [15:0] s_reg, p_reg;
    logic [31:0] n_reg, exp_n_reg;
    logic [7:0]  cs_given_reg, cs_run_reg;

    // Scaling unit
    logic [31:0] mag_reg;
    logic        neg_reg;
    logic [8:0]  cnt_reg;

    logic [OutWidth-1:0] out_reg;

    // Character classification
    logic [7:0] c_up;
    logic       letter, eol, is_star, in_cmt, is_digit;
    always_comb begin
        c_up     = (char_reg >= CH_LA && char_reg <= CH_LZ) ? (char_reg & 8'hDF) : char_reg;
        letter   = c_up >= CH_A && c_up <= CH_Z;
        eol      = c_up == CH_LF || c_up == CH_CR;
        is_star  = c_up == CH_STAR;
        in_cmt   = semi_reg || paren_reg;
        is_digit = c_up >= CH_0 && c_up <= CH_9;
    end

    assign sts.need_close = (pend_reg != 8'd0) && (letter || is_star || eol);
    assign sts.div_done   = (cnt_reg == 9'd0) || (mag_reg == 32'd0);
    assign sts.is_eol     = eol;

    // Select multiplier and extra decades for the open field
    logic [23:0] mult_sel;
    logic [1:0]  extra;
    always_comb begin
        mult_sel = 24'd1;
        extra    = 2'd0;
        case (pend_reg)
            CH_X: mult_sel = scale_x_reg;
            CH_Y: mult_sel = scale_y_reg;
            CH_Z: mult_sel = scale_z_reg;
            CH_E: mult_sel = scale_e_reg;
            CH_F: mult_sel = inch_reg ? 24'd254 : 24'd1;
            CH_S: begin
                if (m_reg == M_TEMP_A || m_reg == M_TEMP_B) begin
                    mult_sel = 24'd4;
                end else if (m_reg >= M_PID_LO && m_reg <= M_PID_HI) begin
                    mult_sel = {8'd0, pid_reg};
                end
            end
            CH_P: mult_sel = (g_reg == G_DWELL) ? 24'd1000 : 24'd1;
            default: mult_sel = 24'd1;
        endcase
        if (!inch_reg && (pend_reg == CH_X || pend_reg == CH_Y ||
                          pend_reg == CH_Z || pend_reg == CH_E)) begin
            extra = 2'd3;
        end else if (inch_reg && pend_reg == CH_F) begin
            extra = 2'd1;
        end
    end

    logic [55:0] prod_full;
    logic [31:0] prod;
    logic [8:0]  dec_base;
    logic        int_min_keep;
    logic [63:0] div_full;
    logic [31:0] result;
    always_comb begin
        prod_full    = mant_reg * mult_sel;
        prod         = prod_full[31:0];
        dec_base     = (exp_reg == 8'd0) ? 9'd0 : ({1'b0, exp_reg} - 9'd1);
        // Negating the most negative value leaves it negative
        int_min_keep = (prod == 32'h80000000) && (extra == 2'd0);
        div_full     = mag_reg * RECIP_10;
        result       = neg_reg ? (32'd0 - mag_reg) : mag_reg;
    end

    // Line-end checks
    logic       n_seen, cs_seen, cs_match, n_ok, cs_ok;
    logic [1:0] status;
    always_comb begin
        n_seen   = seen_reg[BIT_N];
        cs_seen  = seen_reg[BIT_CS];
        cs_match = cs_run_reg == cs_given_reg;
        n_ok     = check_reg[0] ? (n_seen && n_reg >= exp_n_reg) : 1'b1;
        cs_ok    = check_reg[1] ? (cs_match && cs_seen) : (cs_match || !cs_seen);
        if (!n_ok) begin
            status = ST_LINE_N;
        end else if (!cs_ok) begin
            status = ST_CSUM;
        end else begin
            status = ST_OK;
        end
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_x_reg <= 24'd80000;
            scale_y_reg <= 24'd80000;
            scale_z_reg <= 24'd80000;
            scale_e_reg <= 24'd80000;
            inch_reg    <= 1'b0;
            rel_reg     <= 1'b0;
            check_reg   <= 2'd0;
            pid_reg     <= 16'd1024;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_SCALE_X:   scale_x_reg <= cfg_wdata;
                REG_SCALE_Y:   scale_y_reg <= cfg_wdata;
                REG_SCALE_Z:   scale_z_reg <= cfg_wdata;
                REG_SCALE_EXT: scale_e_reg <= cfg_wdata;
                REG_INCH:      inch_reg    <= cfg_wdata[0];
                REG_RELATIVE:  rel_reg     <= cfg_wdata[0];
                REG_CHECK:     check_reg   <= cfg_wdata[1:0];
                REG_PID:       pid_reg     <= cfg_wdata[15:0];
                default:       pid_reg     <= pid_reg;
            endcase
        end
    end

    // Scaling unit and result register (payload, no reset)
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            char_reg <= s_tdata;
        end
        if (cmd.mul) begin
            mag_reg <= prod[31] ? (32'd0 - prod) : prod;
            neg_reg <= prod[31] ^ (sign_reg & !int_min_keep);
            cnt_reg <= dec_base + {7'd0, extra};
        end else if (cmd.div) begin
            mag_reg <= {3'd0, div_full[63:35]};
            cnt_reg <= cnt_reg - 9'd1;
        end
        if (cmd.eol) begin
            out_reg <= {4'd0, n_reg, p_reg, s_reg, tf_reg, te_reg, tz_reg, ty_reg, tx_reg,
                        seen_reg[9:0], m_reg, g_reg, status};
        end
    end

    // Parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg     <= 8'd0;
            sign_reg     <= 1'b0;
            mant_reg     <= 32'd0;
            exp_reg      <= 8'd0;
            g_reg        <= 8'd0;
            m_reg        <= 8'd0;
            seen_reg     <= 11'd0;
            semi_reg     <= 1'b0;
            paren_reg    <= 1'b0;
            tx_reg       <= 32'd0;
            ty_reg       <= 32'd0;
            tz_reg       <= 32'd0;
            te_reg       <= 32'd0;
            tf_reg       <= 32'd0;
            s_reg        <= 16'd0;
            p_reg        <= 16'd0;
            n_reg        <= 32'd0;
            exp_n_reg    <= 32'd0;
            cs_given_reg <= 8'd0;
            cs_run_reg   <= 8'd0;
        end else begin
            // Store the closed field and clear the number
            if (cmd.commit) begin
                case (pend_reg)
                    CH_G:    g_reg        <= mant_reg[7:0];
                    CH_M:    m_reg        <= mant_reg[7:0];
                    CH_X:    tx_reg       <= result;
                    CH_Y:    ty_reg       <= result;
                    CH_Z:    tz_reg       <= result;
                    CH_E:    te_reg       <= result;
                    CH_F:    tf_reg       <= result;
                    CH_S:    s_reg        <= result[15:0];
                    CH_P:    p_reg        <= result[15:0];
                    CH_N:    n_reg        <= result;
                    CH_STAR: cs_given_reg <= result[7:0];
                    default: ;
                endcase
                pend_reg <= 8'd0;
                sign_reg <= 1'b0;
                mant_reg <= 32'd0;
                exp_reg  <= 8'd0;
            end

            // Apply the character
            if (cmd.chr) begin
                if (!in_cmt) begin
                    if (letter || is_star) begin
                        pend_reg <= c_up;
                    end
                    case (c_up)
                        CH_G: begin
                            seen_reg[BIT_G] <= 1'b1;
                            seen_reg[BIT_M] <= 1'b0;
                            m_reg           <= 8'd0;
                        end
                        CH_M: begin
                            seen_reg[BIT_M] <= 1'b1;
                            seen_reg[BIT_G] <= 1'b0;
                            g_reg           <= 8'd0;
                        end
                        CH_X:    seen_reg[BIT_X]  <= 1'b1;
                        CH_Y:    seen_reg[BIT_Y]  <= 1'b1;
                        CH_Z:    seen_reg[BIT_Z]  <= 1'b1;
                        CH_E:    seen_reg[BIT_E]  <= 1'b1;
                        CH_F:    seen_reg[BIT_F]  <= 1'b1;
                        CH_S:    seen_reg[BIT_S]  <= 1'b1;
                        CH_P:    seen_reg[BIT_P]  <= 1'b1;
                        CH_N:    seen_reg[BIT_N]  <= 1'b1;
                        CH_STAR: seen_reg[BIT_CS] <= 1'b1;
                        CH_SEMI: semi_reg <= 1'b1;
                        CH_LPAR: paren_reg <= 1'b1;
                        CH_MINUS: begin
                            sign_reg <= 1'b1;
                            exp_reg  <= 8'd0;
                            mant_reg <= 32'd0;
                        end
                        CH_POINT: begin
                            if (exp_reg == 8'd0) begin
                                exp_reg <= 8'd1;
                            end
                        end
                        default: begin
                            if (is_digit) begin
                                mant_reg <= (mant_reg << 3) + (mant_reg << 1)
                                          + {28'd0, c_up[3:0]};
                                if (exp_reg != 8'd0) begin
                                    exp_reg <= exp_reg + 8'd1;
                                end
                            end
                        end
                    endcase
                end else if (paren_reg && c_up == CH_RPAR) begin
                    paren_reg <= 1'b0;
                end
                // Checksum covers bytes up to the star
                if (!(seen_reg[BIT_CS] || (!in_cmt && is_star))) begin
                    cs_run_reg <= cs_run_reg ^ char_reg;
                end
            end

            // Close the line
            if (cmd.eol) begin
                if (status == ST_OK && seen_reg[BIT_N]) begin
                    exp_n_reg <= n_reg + 32'd1;
                end
                seen_reg     <= 11'd1 << BIT_G;
                g_reg        <= 8'd1;
                semi_reg     <= 1'b0;
                paren_reg    <= 1'b0;
                cs_given_reg <= 8'd0;
                cs_run_reg   <= 8'd0;
                pend_reg     <= 8'd0;
                sign_reg     <= 1'b0;
                mant_reg     <= 32'd0;
                exp_reg      <= 8'd0;
                if (rel_reg) begin
                    tx_reg <= 32'd0;
                    ty_reg <= 32'd0;
                    tz_reg <= 32'd0;
                    te_reg <= 32'd0;
                end
            end
        end
    end

    assign m_tdata = out_reg;

endmodule

// File: design/gcode_line_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcode_line_parser
// Character-stream G-code parser that emits one parsed command per line end.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one ASCII character per transfer in s_tdata.
//   m_ channel: one result per CR or LF; nothing for other characters.
//   cfg_ port: register writes. The user writes only while no character is in
//   work; the block does not enforce this.
// Sequence: this one-character sequencer sets the rate. A character that
//   closes no field passes accept, decode and apply; s_tready returns when
//   idle again. A field close inserts multiply, divide and commit, one step
//   per decade removed by the shared divide-by-ten unit (at most 10 steps, as
//   the magnitude reaches zero). A line end adds a state loading the result.
// Stall: the result register holds while m_tready is low; s_tready stays
//   high, but a following line end waits until the previous result leaves.
// Reset: synchronous active-low aresetn clears all line state, loads the
//   register defaults and drops m_tvalid.
// ----------------------------------------------------------------------------
module gcode_line_parser (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [7:0] char_in
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [1:0] status, [9:2] g_code, [17:10] m_code, [27:18] seen_mask,
    // [59:28] pos_x, [91:60] pos_y, [123:92] pos_z, [155:124] pos_ext,
    // [187:156] feed, [203:188] s_value, [219:204] p_value,
    // [251:220] line_number, [255:252] zero
    output logic [gclp_pkg::OutWidth-1:0]       m_tdata,
    input  logic                                cfg_wr_en,
    input  logic [gclp_pkg::CfgIdxWidth-1:0]    cfg_index,
    input  logic [gclp_pkg::CfgDataWidth-1:0]   cfg_wdata
);
    import gclp_pkg::*;

    cmd_t cmd;
    sts_t sts;

    gclp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    gclp_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tdata   (m_tdata)
    );

    // One character at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a character is in work");

    // Status is one of the three defined codes
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[1:0] != 2'b11)
        else $error("undefined status code");

    // G and M are never both marked present
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[18] && m_tdata[19]))
        else $error("G and M both marked present");

endmodule
